// ===== rtl/msd_pkg.sv =====
// shared types and constants of the multitouch slot event decoder
`default_nettype none
package msd_pkg;

  localparam logic [2:0] OP_SLOT     = 3'd0;
  localparam logic [2:0] OP_X        = 3'd1;
  localparam logic [2:0] OP_Y        = 3'd2;
  localparam logic [2:0] OP_TRACK    = 3'd3;
  localparam logic [2:0] OP_PRESSURE = 3'd4;
  localparam logic [2:0] OP_MAJOR    = 3'd5;
  localparam logic [2:0] OP_BUTTON   = 3'd6;
  localparam logic [2:0] OP_SYNC     = 3'd7;

  localparam logic [2:0] REG_X_MIN  = 3'd0;
  localparam logic [2:0] REG_X_MAX  = 3'd1;
  localparam logic [2:0] REG_Y_MIN  = 3'd2;
  localparam logic [2:0] REG_Y_MAX  = 3'd3;
  localparam logic [2:0] REG_X_GAIN = 3'd4;
  localparam logic [2:0] REG_Y_GAIN = 3'd5;

  localparam logic [13:0] POS_MAX = 14'h3fff;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] event_value;
  } in_item_t;

  typedef struct packed {
    logic        report_kind;
    logic [15:0] contact_slot;
    logic [15:0] contact_id;
    logic [13:0] pos_x;
    logic [13:0] pos_y;
    logic        last_report;
  } out_item_t;

  typedef struct packed {
    logic [15:0] slot;
    logic [13:0] x;
    logic [13:0] y;
    logic [15:0] track;
    logic [15:0] pressure;
    logic [15:0] major;
    logic        seen;
    logic        up;
  } entry_t;

  typedef enum logic [3:0] {
    WR_NONE,
    WR_NEW_SLOT,
    WR_X,
    WR_Y,
    WR_TRACK,
    WR_RELEASE,
    WR_PRESSURE,
    WR_MAJOR,
    WR_BTN_PRESS,
    WR_BTN_UP,
    WR_CLR_SEEN,
    WR_CLEAR
  } wr_op_t;

  // broadcast to every cell
  typedef struct packed {
    wr_op_t      op;
    logic [15:0] data;
    logic [13:0] pos;
  } cell_wr_t;

  // per-cell control
  typedef struct packed {
    logic sel;
    logic shift;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/multitouch_slot_event_decoder_top.sv =====
// multitouch slot event decoder: row of contact cells plus event sequencer
// slot, id, pressure, major and button requests are handled in S_IDLE; x and y pass through S_MUL
// (the gain multiply is registered); a sync walks every live entry in S_SYNC, waits while the
// output side holds back a report, and wipes a lone entry going up in place.
// one request is worked at a time; results leave
// through an output register. reset (synchronous, active low) clears the table,
// counters and control, and sets the configuration registers to their defaults.
`default_nettype none
module multitouch_slot_event_decoder_top
  import msd_pkg::*;
#(
  parameter int MAX_CONTACTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_item_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_CONTACTS);
  localparam int CNT_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_CONTACTS - 1);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_SYNC} state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] top_r, top_nxt;
  logic [IDX_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [15:0]      btn_r, btn_nxt;
  logic [15:0]      mul_v_r, mul_v_nxt;
  logic [31:0]      mul_g_r, mul_g_nxt;
  logic             mul_y_r, mul_y_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;
  logic [15:0]      x_min_r, x_min_nxt, x_max_r, x_max_nxt;
  logic [15:0]      y_min_r, y_min_nxt, y_max_r, y_max_nxt;
  logic [31:0]      x_gain_r, x_gain_nxt, y_gain_r, y_gain_nxt;

  entry_t                  cell_q [MAX_CONTACTS];
  cell_ctl_t               ctl [MAX_CONTACTS];
  logic [MAX_CONTACTS-1:0] match_v;
  logic [MAX_CONTACTS-1:0] live_v;
  logic [MAX_CONTACTS-1:0] rep_v;
  cell_wr_t                wr;
  logic [IDX_W-1:0]        sel_idx;
  logic                    sync_shift;

  logic [IDX_W-1:0]  jj;
  entry_t            cur_e;
  logic              cur_rep;
  logic              later_any;
  logic              sync_done;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  logic [IDX_W-1:0]  tgt;
  logic signed [33:0] sv, hi_s, lo_s, clamp_v, off_v;
  logic [47:0]       prod;
  logic [13:0]       scaled;
  logic              accept;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_CONTACTS; gi++) begin : g_cell
      entry_t nbr;
      if (gi < MAX_CONTACTS - 1) begin : g_mid
        assign nbr = cell_q[gi+1];
      end else begin : g_end
        assign nbr = '0;
      end
      msd_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (wr),
        .ctl        (ctl[gi]),
        .nbr        (nbr),
        .entry      (cell_q[gi]),
        .slot_match (match_v[gi])
      );
      assign live_v[gi]    = (IDX_W'(gi) <= top_r);
      assign rep_v[gi]     = cell_q[gi].seen | cell_q[gi].up;
      assign ctl[gi].sel   = (IDX_W'(gi) == sel_idx);
      assign ctl[gi].shift = sync_shift && (IDX_W'(gi) >= jj);
    end
  endgenerate

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign jj        = j_r[IDX_W-1:0];
  assign cur_e     = cell_q[jj];
  assign cur_rep   = cur_e.seen | cur_e.up;
  assign sync_done = (j_r > {1'b0, top_r});

  always_comb begin
    later_any = 1'b0;
    for (int k = 0; k < MAX_CONTACTS; k++) begin
      if ((CNT_W'(k) > j_r) && live_v[k] && rep_v[k]) later_any = 1'b1;
    end
  end

  // first live entry holding the slot
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int k = MAX_CONTACTS - 1; k >= 0; k--) begin
      if (match_v[k] && live_v[k]) begin
        found     = 1'b1;
        found_idx = IDX_W'(k);
      end
    end
  end

  // clamp to axis max, offset by axis min, floor at zero
  always_comb begin
    sv      = 34'(in_data.event_value);
    hi_s    = $signed({18'b0, (in_data.opcode == OP_Y) ? y_max_r : x_max_r});
    lo_s    = $signed({18'b0, (in_data.opcode == OP_Y) ? y_min_r : x_min_r});
    clamp_v = (sv > hi_s) ? hi_s : sv;
    off_v   = clamp_v - lo_s;
  end

  assign prod   = 48'(mul_v_r) * 48'(mul_g_r);
  assign scaled = (|prod[47:30]) ? POS_MAX : prod[29:16];
  assign tgt    = (top_r < LAST_IDX) ? top_r + 1'b1 : top_r;

  always_comb begin
    state_nxt     = state_r;
    top_nxt       = top_r;
    cur_nxt       = cur_r;
    j_nxt         = j_r;
    btn_nxt       = btn_r;
    mul_v_nxt     = mul_v_r;
    mul_g_nxt     = mul_g_r;
    mul_y_nxt     = mul_y_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_nxt       = out_r;
    x_min_nxt     = x_min_r;
    x_max_nxt     = x_max_r;
    y_min_nxt     = y_min_r;
    y_max_nxt     = y_max_r;
    x_gain_nxt    = x_gain_r;
    y_gain_nxt    = y_gain_r;
    wr.op         = WR_NONE;
    wr.data       = in_data.event_value[15:0];
    wr.pos        = scaled;
    sel_idx       = cur_r;
    sync_shift    = 1'b0;

    if (cfg_valid) begin
      case (cfg_index)
        REG_X_MIN:  x_min_nxt  = cfg_data[15:0];
        REG_X_MAX:  x_max_nxt  = cfg_data[15:0];
        REG_Y_MIN:  y_min_nxt  = cfg_data[15:0];
        REG_Y_MAX:  y_max_nxt  = cfg_data[15:0];
        REG_X_GAIN: x_gain_nxt = cfg_data;
        REG_Y_GAIN: y_gain_nxt = cfg_data;
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.opcode)
            OP_SLOT: begin
              if (found) begin
                cur_nxt = found_idx;
              end else begin
                wr.op   = WR_NEW_SLOT;
                sel_idx = tgt;
                top_nxt = tgt;
                cur_nxt = tgt;
              end
            end
            OP_X, OP_Y: begin
              mul_v_nxt = off_v[33] ? 16'd0 : off_v[15:0];
              mul_g_nxt = (in_data.opcode == OP_Y) ? y_gain_r : x_gain_r;
              mul_y_nxt = (in_data.opcode == OP_Y);
              state_nxt = S_MUL;
            end
            OP_TRACK: begin
              wr.op = (in_data.event_value == -32'sd1) ? WR_RELEASE : WR_TRACK;
            end
            OP_PRESSURE: wr.op = WR_PRESSURE;
            OP_MAJOR:    wr.op = WR_MAJOR;
            OP_BUTTON: begin
              if (in_data.event_value != 32'sd0) begin
                btn_nxt = btn_r + 16'd1;
                wr.data = btn_r + 16'd1;
                wr.op   = WR_BTN_PRESS;
              end else begin
                wr.op = WR_BTN_UP;
              end
            end
            OP_SYNC: begin
              j_nxt     = '0;
              state_nxt = S_SYNC;
            end
            default: ;
          endcase
        end
      end
      S_MUL: begin
        wr.op     = mul_y_r ? WR_Y : WR_X;
        state_nxt = S_IDLE;
      end
      S_SYNC: begin
        if (sync_done) begin
          state_nxt = S_IDLE;
        end else if (!cur_rep || !out_valid_r || out_ready) begin
          if (cur_rep) begin
            out_valid_nxt        = 1'b1;
            out_nxt.report_kind  = cur_e.up;
            out_nxt.contact_slot = cur_e.slot;
            out_nxt.contact_id   = cur_e.track;
            out_nxt.pos_x        = cur_e.x;
            out_nxt.pos_y        = cur_e.y;
            out_nxt.last_report  = !later_any;
          end
          if (cur_e.up) begin
            if (top_r == '0) begin
              // lone entry going up is wiped in place
              wr.op   = WR_CLEAR;
              sel_idx = '0;
              cur_nxt = '0;
            end else begin
              sync_shift = 1'b1;
              top_nxt    = top_r - 1'b1;
            end
          end else begin
            wr.op   = WR_CLR_SEEN;
            sel_idx = jj;
            j_nxt   = j_r + 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= '0;
      cur_r       <= '0;
      j_r         <= '0;
      btn_r       <= '0;
      out_valid_r <= 1'b0;
      x_min_r     <= 16'd0;
      x_max_r     <= 16'd4095;
      y_min_r     <= 16'd0;
      y_max_r     <= 16'd4095;
      x_gain_r    <= 32'd65536;
      y_gain_r    <= 32'd65536;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      cur_r       <= cur_nxt;
      j_r         <= j_nxt;
      btn_r       <= btn_nxt;
      out_valid_r <= out_valid_nxt;
      x_min_r     <= x_min_nxt;
      x_max_r     <= x_max_nxt;
      y_min_r     <= y_min_nxt;
      y_max_r     <= y_max_nxt;
      x_gain_r    <= x_gain_nxt;
      y_gain_r    <= y_gain_nxt;
    end
    mul_v_r <= mul_v_nxt;
    mul_g_r <= mul_g_nxt;
    mul_y_r <= mul_y_nxt;
    out_r   <= out_nxt;
  end

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SYNC) |-> (j_r <= CNT_W'({1'b0, top_r}) + 1'b1))
    else $error("sync walk index ran past the table");

  a_sync_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SYNC && sync_done) |-> ((rep_v & live_v) == '0))
    else $error("live entry still marked after sync");

  a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= LAST_IDX)
    else $error("table top beyond last cell");

endmodule
`default_nettype wire

// ===== rtl/msd_cell.sv =====
// one contact cell: holds an entry, takes writes or its upper neighbor's entry
`default_nettype none
module msd_cell
  import msd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_wr_t  wr,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    nbr,
  output entry_t         entry,
  output logic           slot_match
);

  entry_t entry_r;
  entry_t entry_nxt;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.shift) begin
      entry_nxt = nbr;
    end else if (ctl.sel) begin
      case (wr.op)
        WR_NEW_SLOT: begin
          entry_nxt      = '0;
          entry_nxt.slot = wr.data;
        end
        WR_X: begin
          entry_nxt.x    = wr.pos;
          entry_nxt.seen = 1'b1;
        end
        WR_Y: begin
          entry_nxt.y    = wr.pos;
          entry_nxt.seen = 1'b1;
        end
        WR_TRACK: begin
          entry_nxt.track = wr.data;
          entry_nxt.seen  = 1'b1;
        end
        WR_RELEASE: begin
          entry_nxt.up   = 1'b1;
          entry_nxt.seen = 1'b1;
        end
        WR_PRESSURE: begin
          entry_nxt.pressure = wr.data;
          entry_nxt.seen     = 1'b1;
        end
        WR_MAJOR: begin
          entry_nxt.major = wr.data;
          entry_nxt.seen  = 1'b1;
        end
        WR_BTN_PRESS: begin
          entry_nxt.track = wr.data;
          entry_nxt.up    = 1'b0;
        end
        WR_BTN_UP:   entry_nxt.up   = 1'b1;
        WR_CLR_SEEN: entry_nxt.seen = 1'b0;
        WR_CLEAR:    entry_nxt      = '0;
        default:     entry_nxt      = entry_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r <= '0;
    end else begin
      entry_r <= entry_nxt;
    end
  end

  assign entry      = entry_r;
  assign slot_match = (entry_r.slot == wr.data);

endmodule
`default_nettype wire
